@@ src/bleasp_pkg.sv @@
// Shared types, codes and constants for the advertisement sensor-record parser.
package bleasp_pkg;

  // Record type of manufacturer-specific data.
  localparam logic [7:0] MfrType = 8'hFF;
  // Bytes in the big-endian sensor value.
  localparam logic [7:0] ValueBytes = 8'd4;
  // Shortest packet that is parsed at all.
  localparam logic [2:0] MinPacket = 3'd4;
  // Reset value of the company identifier register.
  localparam logic [15:0] CompanyIdReset = 16'hFFFF;

  typedef enum logic [3:0] {
    PhLen    = 4'd0,
    PhType   = 4'd1,
    PhSkip   = 4'd2,
    PhCidHi  = 4'd3,
    PhCidLo  = 4'd4,
    PhLlen   = 4'd5,
    PhLabel  = 4'd6,
    PhUlen   = 4'd7,
    PhUnit   = 4'd8,
    PhPrec   = 4'd9,
    PhValue  = 4'd10,
    PhErrRec = 4'd11,
    PhErrNoRec = 4'd12,
    PhErrCid = 4'd13,
    PhErrHdr = 4'd14,
    PhErrVal = 4'd15
  } phase_e;

  typedef enum logic [1:0] {
    KindLabel   = 2'd0,
    KindUnit    = 2'd1,
    KindReading = 2'd2,
    KindError   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ErrOk          = 3'd0,
    ErrPacketShort = 3'd1,
    ErrNoRecord    = 3'd2,
    ErrRecordShort = 3'd3,
    ErrBadCompany  = 3'd4,
    ErrHeaderShort = 3'd5,
    ErrValueShort  = 3'd6
  } err_e;

  // One result item plus its presence flag.
  typedef struct packed {
    logic               valid;
    kind_e              kind;
    logic [7:0]         char_byte;
    err_e               error_code;
    logic signed [31:0] sensor_value;
    logic [7:0]         precision;
    logic [7:0]         label_len;
    logic [7:0]         unit_len;
  } result_t;

  // Error reported at the last byte for the phase the parser ends in.
  function automatic err_e phase_error(phase_e ph);
    err_e e;
    case (ph)
      PhLen, PhSkip, PhErrNoRec: e = ErrNoRecord;
      PhErrCid:                  e = ErrBadCompany;
      PhErrHdr:                  e = ErrHeaderShort;
      PhErrVal:                  e = ErrValueShort;
      default:                   e = ErrRecordShort;
    endcase
    return e;
  endfunction

endpackage

@@ src/ble_adv_sensor_record_parser_core.sv @@
// Top level of the advertisement sensor-record parser: config port, parser and output buffer.
//
// Usage: bytes of one advertisement enter on the input channel (data_byte_i,
// last_byte_i) with in_valid_i/in_stall_o; a transfer takes place at a clock
// edge with valid high and stall low. last_byte_i marks the packet's final byte.
// Each byte yields zero or one result on the output channel (out_valid_o /
// out_stall_i): a label or unit character, one reading, or one error at the
// last byte. Results leave in input order.
// A result is registered in the output register, or in the skid register when
// the output register cannot take it. Throughput: one byte per cycle while
// in_stall_o is low, so nothing limits the rate but the receiver.
// When the receiver stalls, the output register holds and a one-entry skid
// register still takes one more result; in_stall_o rises only while that skid
// entry is occupied.
// The company identifier is written through the APB-style port at byte
// address 0; pready is always high and reads return the stored value.
// Reset clears the parse state and both output entries, and sets the company
// identifier to 0xFFFF.
module ble_adv_sensor_record_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  // Output channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         char_byte_o,
  output logic [2:0]         error_code_o,
  output logic signed [31:0] sensor_value_o,
  output logic [7:0]         precision_o,
  output logic [7:0]         label_len_o,
  output logic [7:0]         unit_len_o
);
  import bleasp_pkg::*;

  localparam logic [1:0] AddrCompanyId = 2'd0;

  logic [15:0] cid_q;
  logic        in_accept;
  logic        out_free;
  result_t     res;
  result_t     out_q, out_d;
  result_t     sk_q, sk_d;

  // Configuration register write and read.
  assign pready = 1'b1;
  assign prdata = (paddr == AddrCompanyId) ? {16'd0, cid_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cid_q <= CompanyIdReset;
    end else if (psel && penable && pwrite && pready && (paddr == AddrCompanyId)) begin
      cid_q <= pwdata[15:0];
    end
  end

  // Input transfers are taken while the skid entry is empty.
  assign in_stall_o = sk_q.valid;
  assign in_accept  = in_valid_i && !in_stall_o;

  bleasp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .company_id_i (cid_q),
    .res_o        (res)
  );

  // Output register with a one-entry skid behind it.
  assign out_free = !out_q.valid || !out_stall_i;

  always_comb begin
    result_t fresh;
    fresh       = res;
    fresh.valid = res.valid && in_accept;
    out_d = out_q;
    sk_d  = sk_q;
    if (out_free) begin
      if (sk_q.valid) begin
        out_d = sk_q;
        sk_d  = fresh;
      end else begin
        out_d = fresh;
      end
    end else if (fresh.valid) begin
      sk_d = fresh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
      sk_q  <= '0;
    end else begin
      out_q <= out_d;
      sk_q  <= sk_d;
    end
  end

  assign out_valid_o    = out_q.valid;
  assign kind_o         = out_q.kind;
  assign char_byte_o    = out_q.char_byte;
  assign error_code_o   = out_q.error_code;
  assign sensor_value_o = out_q.sensor_value;
  assign precision_o    = out_q.precision;
  assign label_len_o    = out_q.label_len;
  assign unit_len_o     = out_q.unit_len;

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind an occupied output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_q.valid |-> out_q.valid)
    else $error("skid entry valid while output register empty");

  // The skid entry fills only when the output register was stalled.
  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_q.valid) |-> $past(out_q.valid && out_stall_i))
    else $error("skid entry filled without a stalled output");

  // A result produced against a stalled, full output lands in the skid entry.
  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && res.valid && out_q.valid && out_stall_i) |=> sk_q.valid)
    else $error("result lost while output stalled");

  // An error result always carries a nonzero error code.
  a_error_coded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KindError)) |-> (error_code_o != ErrOk))
    else $error("error result with ok code");
`endif

endmodule

@@ src/bleasp_parser.sv @@
// Byte-wise record walker: parse state registers and the result of the current byte.
module bleasp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  logic [15:0]         company_id_i,
  output bleasp_pkg::result_t res_o
);
  import bleasp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  count_q, count_d;
  logic [7:0]  rec_left_q, rec_left_d;
  logic [7:0]  fld_left_q, fld_left_d;
  logic [31:0] shift_q, shift_d;
  logic [7:0]  prec_q, prec_d;
  logic [7:0]  llen_q, llen_d;
  logic [7:0]  ulen_q, ulen_d;
  logic        reported_q, reported_d;

  logic [7:0] rec_dec;
  logic [7:0] fld_dec;
  logic       ch_out;
  kind_e      ch_kind;
  logic       reading;

  assign rec_dec = rec_left_q - 8'd1;
  assign fld_dec = fld_left_q - 8'd1;

  // Next parse state for the byte on the input.
  always_comb begin
    phase_d    = phase_q;
    count_d    = (count_q < MinPacket) ? count_q + 3'd1 : count_q;
    rec_left_d = rec_left_q;
    fld_left_d = fld_left_q;
    shift_d    = shift_q;
    prec_d     = prec_q;
    llen_d     = llen_q;
    ulen_d     = ulen_q;
    reported_d = reported_q;
    ch_out     = 1'b0;
    ch_kind    = KindLabel;
    reading    = 1'b0;
    if (!reported_q) begin
      case (phase_q)
        PhLen: begin
          if (data_byte_i == 8'd0) begin
            phase_d = PhErrNoRec;
          end else begin
            rec_left_d = data_byte_i;
            phase_d    = PhType;
          end
        end
        PhType: begin
          rec_left_d = rec_dec;
          if (data_byte_i == MfrType) begin
            phase_d = (rec_dec < 8'd2) ? PhErrRec : PhCidHi;
          end else begin
            phase_d = (rec_dec == 8'd0) ? PhLen : PhSkip;
          end
        end
        PhSkip: begin
          rec_left_d = rec_dec;
          if (rec_dec == 8'd0) phase_d = PhLen;
        end
        PhCidHi: begin
          shift_d    = {24'd0, data_byte_i};
          rec_left_d = rec_dec;
          phase_d    = PhCidLo;
        end
        PhCidLo: begin
          rec_left_d = rec_dec;
          if ({shift_q[7:0], data_byte_i} != company_id_i) begin
            phase_d = PhErrCid;
          end else if (rec_dec < ValueBytes) begin
            phase_d = PhErrHdr;
          end else begin
            phase_d = PhLlen;
          end
          shift_d = 32'd0;
        end
        PhLlen: begin
          rec_left_d = rec_dec;
          llen_d     = data_byte_i;
          if ({1'b0, data_byte_i} + 9'd2 > {1'b0, rec_dec}) begin
            phase_d = PhErrHdr;
          end else if (data_byte_i == 8'd0) begin
            phase_d = PhUlen;
          end else begin
            fld_left_d = data_byte_i;
            phase_d    = PhLabel;
          end
        end
        PhLabel, PhUnit: begin
          rec_left_d = rec_dec;
          fld_left_d = fld_dec;
          ch_out     = 1'b1;
          ch_kind    = (phase_q == PhLabel) ? KindLabel : KindUnit;
          if (fld_dec == 8'd0) phase_d = (phase_q == PhLabel) ? PhUlen : PhPrec;
        end
        PhUlen: begin
          rec_left_d = rec_dec;
          ulen_d     = data_byte_i;
          if ({1'b0, data_byte_i} + 9'd1 > {1'b0, rec_dec}) begin
            phase_d = PhErrHdr;
          end else if (data_byte_i == 8'd0) begin
            phase_d = PhPrec;
          end else begin
            fld_left_d = data_byte_i;
            phase_d    = PhUnit;
          end
        end
        PhPrec: begin
          rec_left_d = rec_dec;
          prec_d     = data_byte_i;
          if (rec_dec < ValueBytes) begin
            phase_d = PhErrVal;
          end else begin
            fld_left_d = ValueBytes;
            shift_d    = 32'd0;
            phase_d    = PhValue;
          end
        end
        PhValue: begin
          rec_left_d = rec_dec;
          shift_d    = {shift_q[23:0], data_byte_i};
          fld_left_d = fld_dec;
          if (fld_dec == 8'd0) begin
            reading    = 1'b1;
            reported_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result of this byte, by priority: short packet, reading, error, character.
  always_comb begin
    res_o = '0;
    if (last_byte_i && (count_d < MinPacket)) begin
      res_o.valid      = 1'b1;
      res_o.kind       = KindError;
      res_o.error_code = ErrPacketShort;
    end else if (reading) begin
      res_o.valid        = 1'b1;
      res_o.kind         = KindReading;
      res_o.sensor_value = shift_d;
      res_o.precision    = prec_q;
      res_o.label_len    = llen_q;
      res_o.unit_len     = ulen_q;
    end else if (last_byte_i && !reported_q) begin
      res_o.valid      = 1'b1;
      res_o.kind       = KindError;
      res_o.error_code = phase_error(phase_d);
    end else if (ch_out) begin
      res_o.valid     = 1'b1;
      res_o.kind      = ch_kind;
      res_o.char_byte = data_byte_i;
    end
  end

  // Parse state; everything returns to the start after a packet's last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhLen;
      count_q    <= '0;
      rec_left_q <= '0;
      fld_left_q <= '0;
      shift_q    <= '0;
      prec_q     <= '0;
      llen_q     <= '0;
      ulen_q     <= '0;
      reported_q <= 1'b0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        phase_q    <= PhLen;
        count_q    <= '0;
        rec_left_q <= '0;
        fld_left_q <= '0;
        shift_q    <= '0;
        prec_q     <= '0;
        llen_q     <= '0;
        ulen_q     <= '0;
        reported_q <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        count_q    <= count_d;
        rec_left_q <= rec_left_d;
        fld_left_q <= fld_left_d;
        shift_q    <= shift_d;
        prec_q     <= prec_d;
        llen_q     <= llen_d;
        ulen_q     <= ulen_d;
        reported_q <= reported_d;
      end
    end
  end

endmodule
